### src/lcgr_pkg.sv
package lcgr_pkg;

	localparam int unsigned DataW = 32;

	localparam logic [DataW-1:0] LcgMul = 32'h372ce9b9;
	localparam logic [DataW-1:0] LcgAdd = 32'hb9e92c37;

	localparam logic [2*DataW-1:0] ResetProd =
		(2*DataW)'(LcgMul) * (2*DataW)'(LcgMul) + (2*DataW)'(LcgAdd);
	localparam logic [DataW-1:0] ResetState = ResetProd[DataW-1:0];

	typedef enum logic [1:0] {
		OP_RAW    = 2'd0,
		OP_RANGED = 2'd1,
		OP_RESEED = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [DataW-1:0] lcg_mix(input logic [DataW-1:0] s);
		logic [DataW-1:0] t;
		t = (s << 7) ^ (s >> 9);
		return t >> 1;
	endfunction

endpackage

### src/lcgr_mod.sv
module lcgr_mod (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lcgr_pkg::DataW-1:0]      dividend,
	input  logic [lcgr_pkg::DataW-1:0]      divisor,
	output lcgr_pkg::div_stat_t             stat,
	output logic [lcgr_pkg::DataW-1:0]      remainder
);

	localparam int unsigned CntW = $clog2(lcgr_pkg::DataW);

	logic [lcgr_pkg::DataW-1:0] quo_q;
	logic [lcgr_pkg::DataW-1:0] rem_q;
	logic [lcgr_pkg::DataW-1:0] div_q;
	logic [CntW-1:0]            cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [lcgr_pkg::DataW:0]   shifted;
	logic [lcgr_pkg::DataW+1:0] trial;

	// one restoring subtract per cycle
	assign shifted = {rem_q, quo_q[lcgr_pkg::DataW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(lcgr_pkg::DataW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_q << 1;
			if (trial[lcgr_pkg::DataW+1]) begin
				rem_q <= shifted[lcgr_pkg::DataW-1:0];
			end else begin
				rem_q <= trial[lcgr_pkg::DataW-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

### src/lcg_mixed_random_range.sv
// 32-bit linear congruential generator with a mixed output and a bounded draw.
// s_* carries one command item: opcode 0 raw draw, 1 ranged draw, 2 reseed,
// 3 no operation. every accepted item gives exactly one item on m_*.
// a raw draw or reseed steps the state through the 32x32 multiply-add, then
// loads the output register; a no-op loads the output without a step.
// a ranged draw with range_min < range_max takes the remainder of the mixed
// value by the span from a restoring divider that settles one quotient bit
// per cycle, then range_min is added.
// an inverted or empty range skips the divider.
// one item is in work at a time; s_tready is high only while idle, so a new
// item is taken only after the previous one has left ST_OUT.
// the result sits in an output register, so a new item is taken while the
// previous result waits; if the receiver holds m_tready low, a finished
// item waits in its last step until the output register frees up.
// after arst_n the generator holds one step taken from the multiplier
// constant, no item is in work and m_tvalid is low.
module lcg_mixed_random_range (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[1:0], seed_value[33:2], range_min[65:34], range_max[97:66], zero pad
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// random_value[31:0]
	output logic [31:0]  m_tdata
);

	localparam int unsigned W = lcgr_pkg::DataW;

	lcgr_pkg::state_t  state_q;
	lcgr_pkg::state_t  state_nxt;
	lcgr_pkg::opcode_t op_q;

	logic [W-1:0]   gen_q;
	logic [W-1:0]   seed_q;
	logic [W-1:0]   lo_q;
	logic [W-1:0]   hi_q;
	logic [W-1:0]   span_q;
	logic           inverted_q;
	logic           m_valid_q;
	logic [W-1:0]   m_data_q;

	logic           in_acc;
	logic           out_free;
	logic           do_step;
	logic           div_start;
	logic           load_out;
	logic [W-1:0]   mul_a;
	logic [W-1:0]   prod;
	logic [W-1:0]   gen_nxt;
	logic [W-1:0]   result;
	logic [W-1:0]   rem;

	lcgr_pkg::div_stat_t div_stat;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// multiply-add unit for the generator step
	assign mul_a   = (op_q == lcgr_pkg::OP_RESEED) ? seed_q : gen_q;
	assign prod    = mul_a * lcgr_pkg::LcgMul;
	assign gen_nxt = prod + lcgr_pkg::LcgAdd;

	lcgr_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (lcgr_pkg::lcg_mix(gen_nxt)),
		.divisor   (span_q),
		.stat      (div_stat),
		.remainder (rem)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lcgr_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = lcgr_pkg::ST_STEP;
				end
			end
			lcgr_pkg::ST_STEP: begin
				if (op_q == lcgr_pkg::OP_RANGED && !inverted_q && span_q != '0) begin
					state_nxt = lcgr_pkg::ST_DIV;
				end else begin
					state_nxt = lcgr_pkg::ST_OUT;
				end
			end
			lcgr_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_nxt = lcgr_pkg::ST_OUT;
				end
			end
			lcgr_pkg::ST_OUT: begin
				if (out_free) begin
					state_nxt = lcgr_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lcgr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		do_step   = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			lcgr_pkg::ST_IDLE: s_tready = 1'b1;
			lcgr_pkg::ST_STEP: begin
				case (op_q)
					lcgr_pkg::OP_RAW, lcgr_pkg::OP_RESEED: do_step = 1'b1;
					lcgr_pkg::OP_RANGED: begin
						do_step   = !inverted_q;
						div_start = !inverted_q && span_q != '0;
					end
					default: do_step = 1'b0;
				endcase
			end
			lcgr_pkg::ST_DIV: s_tready = 1'b0;
			lcgr_pkg::ST_OUT: load_out = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	always_comb begin
		case (op_q)
			lcgr_pkg::OP_RAW: result = lcgr_pkg::lcg_mix(gen_q);
			lcgr_pkg::OP_RANGED: begin
				if (inverted_q) begin
					result = hi_q;
				end else if (span_q == '0) begin
					result = lo_q;
				end else begin
					result = lo_q + rem;
				end
			end
			default: result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lcgr_pkg::ST_IDLE;
			gen_q     <= lcgr_pkg::ResetState;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (do_step) begin
				gen_q <= gen_nxt;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q       <= lcgr_pkg::opcode_t'(s_tdata[1:0]);
			seed_q     <= s_tdata[33:2];
			lo_q       <= s_tdata[65:34];
			hi_q       <= s_tdata[97:66];
			span_q     <= s_tdata[97:66] - s_tdata[65:34];
			inverted_q <= s_tdata[65:34] > s_tdata[97:66];
		end
		if (load_out) begin
			m_data_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
